>>> src/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must never hold outside reset
`define LPPT_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define LPPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define LPPT_ASSERT_NEVER(lbl, clk, rst, cond)
`define LPPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

>>> src/lppt_pkg.sv
// types, codes and constants of the linear probe position table
// no dependencies; used by every module of the block
`default_nettype none

package lppt_pkg;

  localparam int KEY_W           = 32;
  localparam int POS_W           = 10;
  localparam int CFG_W           = 11;
  localparam int DEF_TABLE_SLOTS = 1024;
  localparam int CFG_RESET       = 1024;
  localparam int DIV_BITS        = 4;
  localparam int DIV_STEPS       = KEY_W / DIV_BITS;
  localparam int STEP_W          = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH     = 2;
  localparam int OUT_DEPTH       = 2;

  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NOT_FOUND,
    ST_RESERVED
  } status_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_RESERVED
  } op_t;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  position;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  slot_used;
  } out_t;

  // classified request as it travels from front to back
  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } bk_state_t;

endpackage

`default_nettype wire

>>> src/lppt_fifo.sv
// small register queue, used between front and back and on the result side
// depends on lppt_pkg for default sizes
`default_nettype none

module lppt_fifo #(
  parameter int WIDTH = $bits(lppt_pkg::item_t),
  parameter int DEPTH = lppt_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/lppt_front.sv
// front end: takes requests, flags the reserved key, computes the home slot
// depends on lppt_pkg; feeds the queue toward lppt_back
`default_nettype none
`include "assert_macros.svh"

module lppt_front #(
  parameter int TABLE_SLOTS = lppt_pkg::DEF_TABLE_SLOTS,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS),
  parameter int NUM_W       = SLOT_W + 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [NUM_W-1:0]    slots_n,
  input  wire logic                take,
  input  wire lppt_pkg::in_t       request,
  output logic                     busy,
  input  wire logic                q_full,
  output logic                     q_push,
  output lppt_pkg::item_t          q_item,
  output logic [SLOT_W-1:0]        q_home
);

  lppt_pkg::fr_state_t               state;
  lppt_pkg::fr_state_t               state_next;
  lppt_pkg::item_t                   item;
  logic [SLOT_W-1:0]                 rem;
  logic [SLOT_W-1:0]                 rem_next;
  logic [lppt_pkg::KEY_W-1:0]        key_sh;
  logic [lppt_pkg::KEY_W-1:0]        key_sh_next;
  logic [lppt_pkg::STEP_W-1:0]       step;

  // restoring remainder, a few key bits per cycle
  always_comb begin
    logic [NUM_W-1:0]          t;
    logic [SLOT_W-1:0]         r;
    logic [lppt_pkg::KEY_W-1:0] sh;
    r  = rem;
    sh = key_sh;
    for (int i = 0; i < lppt_pkg::DIV_BITS; i++) begin
      t  = {r, sh[lppt_pkg::KEY_W-1]};
      sh = {sh[lppt_pkg::KEY_W-2:0], 1'b0};
      if (t >= slots_n) begin
        t = t - slots_n;
      end
      r = t[SLOT_W-1:0];
    end
    rem_next    = r;
    key_sh_next = sh;
  end

  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    unique case (state)
      lppt_pkg::FR_IDLE: begin
        if (take) begin
          state_next = (request.key == lppt_pkg::EMPTY_KEY) ? lppt_pkg::FR_PUSH
                                                            : lppt_pkg::FR_DIV;
        end
      end
      lppt_pkg::FR_DIV: begin
        if (step == lppt_pkg::STEP_W'(lppt_pkg::DIV_STEPS - 1)) begin
          state_next = lppt_pkg::FR_PUSH;
        end
      end
      lppt_pkg::FR_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = lppt_pkg::FR_IDLE;
        end
      end
      default: state_next = lppt_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lppt_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lppt_pkg::FR_IDLE && take) begin
      item.key      <= request.key;
      item.position <= request.position;
      if (request.key == lppt_pkg::EMPTY_KEY) begin
        item.op <= lppt_pkg::OP_RESERVED;
      end else if (request.kind == lppt_pkg::KIND_INSERT) begin
        item.op <= lppt_pkg::OP_INSERT;
      end else begin
        item.op <= lppt_pkg::OP_LOOKUP;
      end
      rem    <= '0;
      key_sh <= request.key;
      step   <= '0;
    end else if (state == lppt_pkg::FR_DIV) begin
      rem    <= rem_next;
      key_sh <= key_sh_next;
      step   <= step + 1'b1;
    end
  end

  assign busy   = (state != lppt_pkg::FR_IDLE);
  assign q_item = item;
  assign q_home = rem;

  `LPPT_ASSERT_IMPLY(a_push_from_push_state, clk, rst, q_push, state == lppt_pkg::FR_PUSH && !q_full)
  `LPPT_ASSERT_IMPLY(a_home_in_range, clk, rst, q_push, {1'b0, q_home} < slots_n)

endmodule

`default_nettype wire

>>> src/lppt_back.sv
// back end: clears the key memory after reset, then probes slot by slot
// depends on lppt_pkg; reads the front queue, writes the result queue
`default_nettype none
`include "assert_macros.svh"

module lppt_back #(
  parameter int TABLE_SLOTS = lppt_pkg::DEF_TABLE_SLOTS,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS),
  parameter int NUM_W       = SLOT_W + 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [NUM_W-1:0]    slots_n,
  input  wire logic                q_empty,
  input  wire lppt_pkg::item_t     q_item,
  input  wire logic [SLOT_W-1:0]   q_home,
  output logic                     q_pop,
  input  wire logic                out_full,
  output logic                     out_push,
  output lppt_pkg::out_t           out_data,
  output logic                     clearing
);

  logic [lppt_pkg::KEY_W-1:0] key_mem [TABLE_SLOTS];
  logic [lppt_pkg::POS_W-1:0] pos_mem [TABLE_SLOTS];

  lppt_pkg::bk_state_t        state;
  lppt_pkg::bk_state_t        state_next;
  lppt_pkg::op_t              op;
  logic [lppt_pkg::KEY_W-1:0] key;
  logic [lppt_pkg::POS_W-1:0] pos;
  logic [SLOT_W-1:0]          clr_idx;
  logic [SLOT_W-1:0]          rd_idx;
  logic [NUM_W-1:0]           issued;
  logic [NUM_W-1:0]           checked;
  logic                       chk_valid;
  logic [SLOT_W-1:0]          chk_idx;
  logic [lppt_pkg::KEY_W-1:0] rkey;
  logic [lppt_pkg::POS_W-1:0] rpos;
  logic [lppt_pkg::KEY_W-1:0] want;
  logic                       rd_en;
  logic                       load;
  logic                       hit;
  logic                       last;
  logic                       key_we;
  logic                       pos_we;
  logic [SLOT_W-1:0]          wr_addr;
  logic [lppt_pkg::KEY_W-1:0] wr_key;

  assign want     = (op == lppt_pkg::OP_INSERT) ? lppt_pkg::EMPTY_KEY : key;
  assign hit      = chk_valid && (rkey == want);
  assign last     = chk_valid && (NUM_W'(checked + 1'b1) == slots_n);
  assign clearing = (state == lppt_pkg::BK_CLEAR);

  always_comb begin
    state_next              = state;
    q_pop                   = 1'b0;
    load                    = 1'b0;
    rd_en                   = 1'b0;
    out_push                = 1'b0;
    out_data.status         = lppt_pkg::ST_OK;
    out_data.found_position = '0;
    out_data.slot_used      = '0;
    key_we                  = 1'b0;
    pos_we                  = 1'b0;
    wr_addr                 = chk_idx;
    wr_key                  = key;
    unique case (state)
      lppt_pkg::BK_CLEAR: begin
        key_we  = 1'b1;
        wr_addr = clr_idx;
        wr_key  = lppt_pkg::EMPTY_KEY;
        if (clr_idx == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_next = lppt_pkg::BK_IDLE;
        end
      end
      lppt_pkg::BK_IDLE: begin
        if (!q_empty && !out_full) begin
          q_pop = 1'b1;
          if (q_item.op == lppt_pkg::OP_RESERVED) begin
            out_push        = 1'b1;
            out_data.status = lppt_pkg::ST_RESERVED;
          end else begin
            load       = 1'b1;
            state_next = lppt_pkg::BK_PROBE;
          end
        end
      end
      lppt_pkg::BK_PROBE: begin
        rd_en = (issued != slots_n);
        if (hit) begin
          out_push           = 1'b1;
          out_data.slot_used = lppt_pkg::POS_W'(chk_idx);
          if (op == lppt_pkg::OP_INSERT) begin
            key_we = 1'b1;
            pos_we = 1'b1;
          end else begin
            out_data.found_position = rpos;
          end
          state_next = lppt_pkg::BK_IDLE;
        end else if (last) begin
          out_push        = 1'b1;
          out_data.status = (op == lppt_pkg::OP_INSERT) ? lppt_pkg::ST_FULL
                                                        : lppt_pkg::ST_NOT_FOUND;
          state_next      = lppt_pkg::BK_IDLE;
        end
      end
      default: state_next = lppt_pkg::BK_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lppt_pkg::BK_CLEAR;
      clr_idx   <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
      end
      chk_valid <= rd_en;
    end
  end

  // probe pointers: issue one read per cycle, check the one issued before
  always_ff @(posedge clk) begin
    if (load) begin
      op      <= q_item.op;
      key     <= q_item.key;
      pos     <= q_item.position;
      rd_idx  <= q_home;
      issued  <= '0;
      checked <= '0;
    end else if (state == lppt_pkg::BK_PROBE) begin
      chk_idx <= rd_idx;
      if (rd_en) begin
        rd_idx <= (NUM_W'({1'b0, rd_idx} + 1'b1) == slots_n) ? '0 : rd_idx + 1'b1;
        issued <= issued + 1'b1;
      end
      if (chk_valid) begin
        checked <= checked + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      rkey <= key_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= pos;
    end
    if (rd_en) begin
      rpos <= pos_mem[rd_idx];
    end
  end

  `LPPT_ASSERT_NEVER(a_no_pop_while_clearing, clk, rst, q_pop && clearing)
  `LPPT_ASSERT_NEVER(a_no_result_overflow, clk, rst, out_push && out_full)
  `LPPT_ASSERT_NEVER(a_issue_bounded, clk, rst, (state == lppt_pkg::BK_PROBE) && (issued > slots_n))
  `LPPT_ASSERT_IMPLY(a_probe_result_checked, clk, rst, out_push && state == lppt_pkg::BK_PROBE, chk_valid)

endmodule

`default_nettype wire

>>> src/linear_probe_position_table_top.sv
// top level of the linear probe position table: config register, front,
// request queue, back and result queue; depends on lppt_pkg and all lppt_ modules
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// request   | push / full          | request: kind, key, position
// result    | empty / pop          | result: status, found_position, slot_used
// config    | cfg_we (no wait)     | cfg_data: slots in use
//
// reset: the back clears the key memory one slot a cycle, full high until the clear is done
// front: FR_IDLE takes a request, FR_DIV works out the home slot remainder,
//   FR_PUSH queues it and waits while the queue is full; a reserved key skips the remainder
// back: pops in BK_IDLE, then probes slot by slot in BK_PROBE, compare on registered keys
// the front's remainder unit sets the rate at short chains; the front takes no new request until the last is queued
// a full result queue stalls the back; the front keeps working until the request queue fills
module linear_probe_position_table_top #(
  parameter int TABLE_SLOTS = lppt_pkg::DEF_TABLE_SLOTS,
  parameter int QUEUE_DEPTH = lppt_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = lppt_pkg::OUT_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire lppt_pkg::in_t               request,
  output logic                             empty,
  input  wire logic                        pop,
  output lppt_pkg::out_t                   result,
  input  wire logic                        cfg_we,
  input  wire logic [lppt_pkg::CFG_W-1:0]  cfg_data
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int NUM_W   = SLOT_W + 1;
  localparam int RESET_N = (lppt_pkg::CFG_RESET > TABLE_SLOTS) ? TABLE_SLOTS
                                                               : lppt_pkg::CFG_RESET;
  localparam int Q_W     = $bits(lppt_pkg::item_t) + SLOT_W;
  localparam int OUT_W   = $bits(lppt_pkg::out_t);

  // effective slot count, already clamped to 1..TABLE_SLOTS
  logic [NUM_W-1:0]      slots_n;
  logic [31:0]           cfg_wide;
  logic [31:0]           cfg_clamped;

  logic                  fr_busy;
  logic                  clearing;
  logic                  take;

  // front to request queue
  logic                  fq_push;
  lppt_pkg::item_t       fq_item;
  logic [SLOT_W-1:0]     fq_home;
  logic                  q_full;

  // request queue to back
  logic [Q_W-1:0]        q_rd_data;
  logic                  q_empty;
  logic                  q_pop;
  lppt_pkg::item_t       bq_item;
  logic [SLOT_W-1:0]     bq_home;

  // back to result queue
  logic                  res_push;
  lppt_pkg::out_t        res_data;
  logic                  res_full;
  logic [OUT_W-1:0]      res_rd_data;

  // zero count means one slot, counts past the table saturate
  assign cfg_wide    = 32'(cfg_data);
  assign cfg_clamped = (cfg_wide == '0)                ? 32'd1 :
                       (cfg_wide > 32'(TABLE_SLOTS))   ? 32'(TABLE_SLOTS) :
                                                         cfg_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_n <= NUM_W'(RESET_N);
    end else if (cfg_we) begin
      slots_n <= NUM_W'(cfg_clamped);
    end
  end

  // no request is taken while the front is busy or the memory is clearing
  assign full = fr_busy || clearing;
  assign take = push && !full;

  lppt_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W),
    .NUM_W       (NUM_W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .slots_n (slots_n),
    .take    (take),
    .request (request),
    .busy    (fr_busy),
    .q_full  (q_full),
    .q_push  (fq_push),
    .q_item  (fq_item),
    .q_home  (fq_home)
  );

  // short queue of classified requests with their home slot
  lppt_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data ({fq_home, fq_item}),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign bq_home = q_rd_data[Q_W-1 -: SLOT_W];
  assign bq_item = lppt_pkg::item_t'(q_rd_data[$bits(lppt_pkg::item_t)-1:0]);

  lppt_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W),
    .NUM_W       (NUM_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .slots_n  (slots_n),
    .q_empty  (q_empty),
    .q_item   (bq_item),
    .q_home   (bq_home),
    .q_pop    (q_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_data),
    .clearing (clearing)
  );

  // result queue decouples the back from the consumer
  lppt_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_data),
    .empty   (empty)
  );

  assign result = lppt_pkg::out_t'(res_rd_data);

endmodule

`default_nettype wire
